// ===== src/cot_pkg.sv =====
// Shared types and constants for the outer tangent point pipeline.
`timescale 1ns / 1ps

package cot_pkg;

    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = COORD_W - 1;
    localparam int UNIT_BITS  = 30;
    localparam int NORM_W     = 30;
    localparam int D2_W       = 2 * NORM_W + 1;
    localparam int ROOT_W     = 31;
    localparam int SQ_STAGES  = 31;
    localparam int SQ_W       = D2_W + 1;
    localparam int NUM_W      = 63;
    localparam int DIV_PRE    = 9;
    localparam int DIV_STAGES = 40;
    localparam int REM_W      = D2_W + 1;
    localparam int Q_W        = UNIT_BITS + 1;
    localparam int PROD_W     = RADIUS_W + Q_W;
    localparam int LANES      = 4;
    localparam int POINTS     = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0]  first_center_x;
        logic signed [COORD_W-1:0]  first_center_y;
        logic        [RADIUS_W-1:0] first_radius;
        logic signed [COORD_W-1:0]  second_center_x;
        logic signed [COORD_W-1:0]  second_center_y;
        logic        [RADIUS_W-1:0] second_radius;
    } circle_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] upper_first_point_x;
        logic signed [COORD_W-1:0] upper_first_point_y;
        logic signed [COORD_W-1:0] upper_second_point_x;
        logic signed [COORD_W-1:0] upper_second_point_y;
        logic signed [COORD_W-1:0] lower_first_point_x;
        logic signed [COORD_W-1:0] lower_first_point_y;
        logic signed [COORD_W-1:0] lower_second_point_x;
        logic signed [COORD_W-1:0] lower_second_point_y;
        logic                      tangents_valid;
    } tangent_word_t;

    // context that rides alongside each item
    typedef struct packed {
        logic                      tv;
        logic                      nx;
        logic                      ny;
        logic                      nk;
        logic [LANES-1:0]          qneg;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [RADIUS_W-1:0]       r1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [RADIUS_W-1:0]       r2;
        logic [NORM_W-1:0]         axn;
        logic [NORM_W-1:0]         ayn;
        logic [NORM_W-1:0]         akn;
        logic [D2_W-1:0]           d2;
    } ctx_t;

endpackage

// ===== src/circle_outer_tangent_points_top.sv =====
// Top level: outer tangent points of two circles, fully pipelined.
// Throughput: one word per cycle; a stalled output freezes every stage.
// The square root (31 stages) and the normal divider (40 stages) set the depth.
// Reset clears the stage valid flags only; no clearing pass is needed.
`timescale 1ns / 1ps

module circle_outer_tangent_points_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   circle_valid,
    output logic                   circle_stall,
    input  cot_pkg::circle_word_t  circle_word,
    output logic                   tangent_valid,
    input  logic                   tangent_stall,
    output cot_pkg::tangent_word_t tangent_word
);

    localparam int CW = cot_pkg::COORD_W;
    localparam int RW = cot_pkg::RADIUS_W;
    localparam int NW = cot_pkg::NORM_W;
    localparam int DW = cot_pkg::D2_W;
    localparam int L  = cot_pkg::LANES;
    localparam int P  = cot_pkg::POINTS;
    localparam int QW = cot_pkg::Q_W;
    localparam int PW = cot_pkg::PROD_W;
    localparam int UB = cot_pkg::UNIT_BITS;
    localparam int NUMW = cot_pkg::NUM_W;
    localparam int DQW  = cot_pkg::DIV_STAGES;
    localparam int PBW  = $clog2(CW);

    logic ce;

    // ---------------- stage 1: differences
    logic          s1_vld_reg;
    cot_pkg::ctx_t s1_ctx_reg, s1_ctx_next;
    logic [CW-1:0] s1_ax_reg, s1_ax_next, s1_ay_reg, s1_ay_next;
    logic [RW-1:0] s1_ak_reg, s1_ak_next;

    always_comb
    begin
        logic signed [CW:0]   sdx;
        logic signed [CW:0]   sdy;
        logic signed [CW-1:0] sdk;
        sdx = (CW+1)'(circle_word.second_center_x) - (CW+1)'(circle_word.first_center_x);
        sdy = (CW+1)'(circle_word.second_center_y) - (CW+1)'(circle_word.first_center_y);
        sdk = $signed({1'b0, circle_word.first_radius})
            - $signed({1'b0, circle_word.second_radius});
        s1_ax_next = sdx[CW] ? CW'(-sdx) : sdx[CW-1:0];
        s1_ay_next = sdy[CW] ? CW'(-sdy) : sdy[CW-1:0];
        s1_ak_next = sdk[CW-1] ? RW'(-sdk) : sdk[RW-1:0];
        s1_ctx_next      = '0;
        s1_ctx_next.nx   = sdx[CW];
        s1_ctx_next.ny   = sdy[CW];
        s1_ctx_next.nk   = sdk[CW-1];
        s1_ctx_next.x1   = circle_word.first_center_x;
        s1_ctx_next.y1   = circle_word.first_center_y;
        s1_ctx_next.r1   = circle_word.first_radius;
        s1_ctx_next.x2   = circle_word.second_center_x;
        s1_ctx_next.y2   = circle_word.second_center_y;
        s1_ctx_next.r2   = circle_word.second_radius;
    end

    // ---------------- stage 2: full-width squares, leading one
    logic              s2_vld_reg;
    cot_pkg::ctx_t     s2_ctx_reg;
    logic [CW-1:0]     s2_ax_reg, s2_ay_reg;
    logic [RW-1:0]     s2_ak_reg;
    logic [2*CW-1:0]   s2_xx_reg, s2_xx_next, s2_yy_reg, s2_yy_next;
    logic [2*RW-1:0]   s2_kk_reg, s2_kk_next;
    logic [PBW-1:0]    s2_lead_reg, s2_lead_next;

    always_comb
    begin
        logic [CW-1:0] m;
        s2_xx_next = s1_ax_reg * s1_ax_reg;
        s2_yy_next = s1_ay_reg * s1_ay_reg;
        s2_kk_next = s1_ak_reg * s1_ak_reg;
        m = s1_ax_reg | s1_ay_reg | CW'(s1_ak_reg);
        s2_lead_next = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (m[i])
            begin
                s2_lead_next = PBW'(i);
            end
        end
    end

    // ---------------- stage 3: existence test, normalisation
    logic          s3_vld_reg;
    cot_pkg::ctx_t s3_ctx_reg, s3_ctx_next;

    always_comb
    begin
        logic [2*CW:0] sum;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] sk;
        sum = (2*CW+1)'(s2_xx_reg) + (2*CW+1)'(s2_yy_reg);
        if (s2_lead_reg >= PBW'(NW - 1))
        begin
            sx = s2_ax_reg >> (s2_lead_reg - PBW'(NW - 1));
            sy = s2_ay_reg >> (s2_lead_reg - PBW'(NW - 1));
            sk = CW'(s2_ak_reg) >> (s2_lead_reg - PBW'(NW - 1));
        end
        else
        begin
            sx = s2_ax_reg << (PBW'(NW - 1) - s2_lead_reg);
            sy = s2_ay_reg << (PBW'(NW - 1) - s2_lead_reg);
            sk = CW'(s2_ak_reg) << (PBW'(NW - 1) - s2_lead_reg);
        end
        s3_ctx_next     = s2_ctx_reg;
        s3_ctx_next.tv  = ((s2_ax_reg | s2_ay_reg) != '0)
                        && (sum >= (2*CW+1)'(s2_kk_reg));
        s3_ctx_next.axn = sx[NW-1:0];
        s3_ctx_next.ayn = sy[NW-1:0];
        s3_ctx_next.akn = sk[NW-1:0];
    end

    // ---------------- stage 4: normalised squares
    logic            s4_vld_reg;
    cot_pkg::ctx_t   s4_ctx_reg;
    logic [2*NW-1:0] s4_sx_reg, s4_sy_reg, s4_sk_reg;

    // ---------------- stage 5: d^2 and radicand
    logic          s5_vld_reg;
    cot_pkg::ctx_t s5_ctx_reg, s5_ctx_next;
    logic [DW-1:0] s5_rad_reg, s5_rad_next;

    always_comb
    begin
        logic [DW-1:0] d2;
        d2 = DW'(s4_sx_reg) + DW'(s4_sy_reg);
        s5_rad_next    = (d2 > DW'(s4_sk_reg)) ? d2 - DW'(s4_sk_reg) : '0;
        s5_ctx_next    = s4_ctx_reg;
        s5_ctx_next.d2 = d2;
        s5_ctx_next.tv = s4_ctx_reg.tv && (d2 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_vld_reg <= circle_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_ctx_reg  <= s1_ctx_next;
            s1_ax_reg   <= s1_ax_next;
            s1_ay_reg   <= s1_ay_next;
            s1_ak_reg   <= s1_ak_next;
            s2_ctx_reg  <= s1_ctx_reg;
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_ak_reg   <= s1_ak_reg;
            s2_xx_reg   <= s2_xx_next;
            s2_yy_reg   <= s2_yy_next;
            s2_kk_reg   <= s2_kk_next;
            s2_lead_reg <= s2_lead_next;
            s3_ctx_reg  <= s3_ctx_next;
            s4_ctx_reg  <= s3_ctx_reg;
            s4_sx_reg   <= s3_ctx_reg.axn * s3_ctx_reg.axn;
            s4_sy_reg   <= s3_ctx_reg.ayn * s3_ctx_reg.ayn;
            s4_sk_reg   <= s3_ctx_reg.akn * s3_ctx_reg.akn;
            s5_ctx_reg  <= s5_ctx_next;
            s5_rad_reg  <= s5_rad_next;
        end
    end

    // ---------------- square root
    logic                       sq_vld;
    logic [cot_pkg::ROOT_W-1:0] sq_root;
    cot_pkg::ctx_t              sq_ctx;

    cot_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (s5_vld_reg),
        .rad     (s5_rad_reg),
        .in_ctx  (s5_ctx_reg),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_ctx (sq_ctx)
    );

    // ---------------- products for the normal numerators
    logic                   p1_vld_reg;
    cot_pkg::ctx_t          p1_ctx_reg;
    logic signed [NUMW-1:0] p1_xk_reg, p1_xk_next, p1_yh_reg, p1_yh_next;
    logic signed [NUMW-1:0] p1_yk_reg, p1_yk_next, p1_xh_reg, p1_xh_next;

    always_comb
    begin
        logic signed [NW:0] dxs;
        logic signed [NW:0] dys;
        logic signed [NW:0] ks;
        logic signed [cot_pkg::ROOT_W:0] hs;
        dxs = sq_ctx.nx ? -$signed({1'b0, sq_ctx.axn}) : $signed({1'b0, sq_ctx.axn});
        dys = sq_ctx.ny ? -$signed({1'b0, sq_ctx.ayn}) : $signed({1'b0, sq_ctx.ayn});
        ks  = sq_ctx.nk ? -$signed({1'b0, sq_ctx.akn}) : $signed({1'b0, sq_ctx.akn});
        hs  = $signed({1'b0, sq_root});
        p1_xk_next = dxs * ks;
        p1_yh_next = dys * hs;
        p1_yk_next = dys * ks;
        p1_xh_next = dxs * hs;
    end

    // ---------------- numerators, magnitude and sign
    logic            p2_vld_reg;
    cot_pkg::ctx_t   p2_ctx_reg, p2_ctx_next;
    logic [NUMW-1:0] p2_num_reg  [0:L-1];
    logic [NUMW-1:0] p2_num_next [0:L-1];

    always_comb
    begin
        logic signed [NUMW:0] n [0:L-1];
        n[0] = (NUMW+1)'(p1_xk_reg) - (NUMW+1)'(p1_yh_reg);
        n[1] = (NUMW+1)'(p1_yk_reg) + (NUMW+1)'(p1_xh_reg);
        n[2] = (NUMW+1)'(p1_xk_reg) + (NUMW+1)'(p1_yh_reg);
        n[3] = (NUMW+1)'(p1_yk_reg) - (NUMW+1)'(p1_xh_reg);
        p2_ctx_next = p1_ctx_reg;
        for (int l = 0; l < L; l++)
        begin
            p2_ctx_next.qneg[l] = n[l][NUMW];
            p2_num_next[l]      = n[l][NUMW] ? NUMW'(-n[l]) : n[l][NUMW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            p1_vld_reg <= sq_vld;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_ctx_reg <= sq_ctx;
            p1_xk_reg  <= p1_xk_next;
            p1_yh_reg  <= p1_yh_next;
            p1_yk_reg  <= p1_yk_next;
            p1_xh_reg  <= p1_xh_next;
            p2_ctx_reg <= p2_ctx_next;
            for (int l = 0; l < L; l++)
            begin
                p2_num_reg[l] <= p2_num_next[l];
            end
        end
    end

    // ---------------- divider
    logic           dv_vld;
    logic [DQW-1:0] dv_quo [0:L-1];
    cot_pkg::ctx_t  dv_ctx;

    cot_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (p2_vld_reg),
        .num     (p2_num_reg),
        .in_ctx  (p2_ctx_reg),
        .out_vld (dv_vld),
        .quo     (dv_quo),
        .out_ctx (dv_ctx)
    );

    // ---------------- rounding and clamp to 1.0
    logic          r_vld_reg;
    cot_pkg::ctx_t r_ctx_reg;
    logic [QW-1:0] r_q_reg  [0:L-1];
    logic [QW-1:0] r_q_next [0:L-1];

    always_comb
    begin
        logic [DQW-1:0] qr;
        for (int l = 0; l < L; l++)
        begin
            qr = (dv_quo[l] + DQW'(1)) >> 1;
            r_q_next[l] = (qr > (DQW'(1) << UB)) ? (QW'(1) << UB) : qr[QW-1:0];
        end
    end

    // ---------------- radius times normal
    logic          m_vld_reg;
    cot_pkg::ctx_t m_ctx_reg;
    logic [PW-1:0] m_prod_reg  [0:P-1];
    logic [PW-1:0] m_prod_next [0:P-1];

    always_comb
    begin
        int lane;
        for (int k = 0; k < P; k++)
        begin
            lane = (k / 4) * 2 + (k % 2);
            m_prod_next[k] = ((k % 4) >= 2)
                           ? PW'(r_ctx_reg.r2) * PW'(r_q_reg[lane])
                           : PW'(r_ctx_reg.r1) * PW'(r_q_reg[lane]);
        end
    end

    // ---------------- placement with saturation, output register
    logic                   out_vld_reg;
    cot_pkg::tangent_word_t out_word_reg, out_word_next;

    function automatic logic signed [CW-1:0] place(
        input logic signed [CW-1:0] c,
        input logic [PW-1:0]        prod,
        input logic                 neg
    );
        logic [PW:0]          rnd;
        logic signed [CW+2:0] off;
        logic signed [CW+2:0] sum;
        logic signed [CW-1:0] res;
        rnd = (PW+1)'(prod) + ((PW+1)'(1) << (UB - 1));
        off = $signed((CW+3)'(rnd >> UB));
        sum = neg ? (CW+3)'(c) - off : (CW+3)'(c) + off;
        if (sum[CW+2:CW-1] == '0 || sum[CW+2:CW-1] == '1)
        begin
            res = sum[CW-1:0];
        end
        else if (sum[CW+2])
        begin
            res = {1'b1, (CW-1)'(0)};
        end
        else
        begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb
    begin
        logic signed [CW-1:0] pt [0:P-1];
        logic signed [CW-1:0] cen;
        int lane;
        for (int k = 0; k < P; k++)
        begin
            lane = (k / 4) * 2 + (k % 2);
            unique case (k % 4)
                0:       cen = m_ctx_reg.x1;
                1:       cen = m_ctx_reg.y1;
                2:       cen = m_ctx_reg.x2;
                default: cen = m_ctx_reg.y2;
            endcase
            pt[k] = m_ctx_reg.tv ? place(cen, m_prod_reg[k], m_ctx_reg.qneg[lane]) : '0;
        end
        out_word_next.upper_first_point_x  = pt[0];
        out_word_next.upper_first_point_y  = pt[1];
        out_word_next.upper_second_point_x = pt[2];
        out_word_next.upper_second_point_y = pt[3];
        out_word_next.lower_first_point_x  = pt[4];
        out_word_next.lower_first_point_y  = pt[5];
        out_word_next.lower_second_point_x = pt[6];
        out_word_next.lower_second_point_y = pt[7];
        out_word_next.tangents_valid       = m_ctx_reg.tv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            r_vld_reg   <= dv_vld;
            m_vld_reg   <= r_vld_reg;
            out_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_ctx_reg    <= dv_ctx;
            m_ctx_reg    <= r_ctx_reg;
            out_word_reg <= out_word_next;
            for (int l = 0; l < L; l++)
            begin
                r_q_reg[l] <= r_q_next[l];
            end
            for (int k = 0; k < P; k++)
            begin
                m_prod_reg[k] <= m_prod_next[k];
            end
        end
    end

    assign ce            = ~(out_vld_reg & tangent_stall);
    assign circle_stall  = ~ce;
    assign tangent_valid = out_vld_reg;
    assign tangent_word  = out_word_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tangent_valid && !tangent_word.tangents_valid |->
            tangent_word.upper_first_point_x == '0 && tangent_word.upper_first_point_y == '0
            && tangent_word.upper_second_point_x == '0
            && tangent_word.upper_second_point_y == '0
            && tangent_word.lower_first_point_x == '0 && tangent_word.lower_first_point_y == '0
            && tangent_word.lower_second_point_x == '0
            && tangent_word.lower_second_point_y == '0)
        else $error("invalid tangent word carries coordinates");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        circle_stall |-> tangent_valid && tangent_stall)
        else $error("input stalled without a blocked output word");

    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        ce && m_vld_reg |=> tangent_valid)
        else $error("word lost before the output register");

endmodule

// ===== src/cot_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module cot_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         ce,
    input  logic                         in_vld,
    input  logic [cot_pkg::D2_W-1:0]     rad,
    input  cot_pkg::ctx_t                in_ctx,
    output logic                         out_vld,
    output logic [cot_pkg::ROOT_W-1:0]   root,
    output cot_pkg::ctx_t                out_ctx
);

    localparam int N = cot_pkg::SQ_STAGES;
    localparam int W = cot_pkg::SQ_W;

    logic [N:1]    vld_reg;
    logic [W-1:0]  v_reg   [1:N];
    logic [W-1:0]  res_reg [1:N];
    cot_pkg::ctx_t ctx_reg [1:N];

    logic [W-1:0]  v_cur    [0:N-1];
    logic [W-1:0]  res_cur  [0:N-1];
    cot_pkg::ctx_t ctx_cur  [0:N-1];
    logic [W-1:0]  v_next   [0:N-1];
    logic [W-1:0]  res_next [0:N-1];

    assign v_cur[0]   = W'(rad);
    assign res_cur[0] = '0;
    assign ctx_cur[0] = in_ctx;

    for (genvar g = 1; g < N; g++)
    begin : g_link
        assign v_cur[g]   = v_reg[g];
        assign res_cur[g] = res_reg[g];
        assign ctx_cur[g] = ctx_reg[g];
    end

    always_comb
    begin
        logic [W-1:0] bitv;
        logic [W-1:0] trial;
        for (int i = 0; i < N; i++)
        begin
            bitv  = W'(1) << (2 * (N - 1 - i));
            trial = res_cur[i] + bitv;
            if (v_cur[i] >= trial)
            begin
                v_next[i]   = v_cur[i] - trial;
                res_next[i] = (res_cur[i] >> 1) + bitv;
            end
            else
            begin
                v_next[i]   = v_cur[i];
                res_next[i] = res_cur[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[N-1:1], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < N; i++)
            begin
                v_reg[i+1]   <= v_next[i];
                res_reg[i+1] <= res_next[i];
                ctx_reg[i+1] <= ctx_cur[i];
            end
        end
    end

    assign out_vld = vld_reg[N];
    assign root    = res_reg[N][cot_pkg::ROOT_W-1:0];
    assign out_ctx = ctx_reg[N];

endmodule

// ===== src/cot_div.sv =====
// Four-lane pipelined restoring divider for the unit normal components.
`timescale 1ns / 1ps

module cot_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_vld,
    input  logic [cot_pkg::NUM_W-1:0]   num [0:cot_pkg::LANES-1],
    input  cot_pkg::ctx_t               in_ctx,
    output logic                        out_vld,
    output logic [cot_pkg::DIV_STAGES-1:0] quo [0:cot_pkg::LANES-1],
    output cot_pkg::ctx_t               out_ctx
);

    localparam int N  = cot_pkg::DIV_STAGES;
    localparam int L  = cot_pkg::LANES;
    localparam int RW = cot_pkg::REM_W;
    localparam int PB = cot_pkg::DIV_PRE;

    logic [N:1]    vld_reg;
    logic [RW-1:0] rem_reg  [1:N][0:L-1];
    logic [N-1:0]  tail_reg [1:N][0:L-1];
    logic [N-1:0]  q_reg    [1:N][0:L-1];
    cot_pkg::ctx_t ctx_reg  [1:N];

    logic [RW-1:0] rem_cur   [0:N-1][0:L-1];
    logic [N-1:0]  tail_cur  [0:N-1][0:L-1];
    logic [N-1:0]  q_cur     [0:N-1][0:L-1];
    cot_pkg::ctx_t ctx_cur   [0:N-1];
    logic [RW-1:0] rem_next  [0:N-1][0:L-1];
    logic [N-1:0]  tail_next [0:N-1][0:L-1];
    logic [N-1:0]  q_next    [0:N-1][0:L-1];

    for (genvar l = 0; l < L; l++)
    begin : g_lane
        assign rem_cur[0][l]  = RW'(num[l] >> PB);
        assign tail_cur[0][l] = {num[l][PB-1:0], (N - PB)'(0)};
        assign q_cur[0][l]    = '0;
        for (genvar g = 1; g < N; g++)
        begin : g_link
            assign rem_cur[g][l]  = rem_reg[g][l];
            assign tail_cur[g][l] = tail_reg[g][l];
            assign q_cur[g][l]    = q_reg[g][l];
        end
    end

    assign ctx_cur[0] = in_ctx;
    for (genvar g = 1; g < N; g++)
    begin : g_ctx
        assign ctx_cur[g] = ctx_reg[g];
    end

    always_comb
    begin
        logic [RW-1:0] shifted;
        for (int i = 0; i < N; i++)
        begin
            for (int l = 0; l < L; l++)
            begin
                shifted         = {rem_cur[i][l][RW-2:0], tail_cur[i][l][N-1]};
                tail_next[i][l] = tail_cur[i][l] << 1;
                if (shifted >= RW'(ctx_cur[i].d2))
                begin
                    rem_next[i][l] = shifted - RW'(ctx_cur[i].d2);
                    q_next[i][l]   = {q_cur[i][l][N-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i][l] = shifted;
                    q_next[i][l]   = {q_cur[i][l][N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[N-1:1], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < N; i++)
            begin
                ctx_reg[i+1] <= ctx_cur[i];
                for (int l = 0; l < L; l++)
                begin
                    rem_reg[i+1][l]  <= rem_next[i][l];
                    tail_reg[i+1][l] <= tail_next[i][l];
                    q_reg[i+1][l]    <= q_next[i][l];
                end
            end
        end
    end

    assign out_vld = vld_reg[N];
    assign out_ctx = ctx_reg[N];
    for (genvar l = 0; l < L; l++)
    begin : g_out
        assign quo[l] = q_reg[N][l];
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the outer tangent point pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 81;

    logic                   clk;
    logic                   rst_n;
    logic                   circle_valid;
    logic                   circle_stall;
    cot_pkg::circle_word_t  circle_word;
    logic                   tangent_valid;
    logic                   tangent_stall;
    cot_pkg::tangent_word_t tangent_word;

    cot_pkg::circle_word_t  pending_circles[$];
    cot_pkg::tangent_word_t expected_tangents[$];
    int            fail_count;
    int            send_idle_pct;
    int            stall_pct;
    bit            hold_off;
    int            hold_count;

    circle_outer_tangent_points_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .circle_valid  (circle_valid),
        .circle_stall  (circle_stall),
        .circle_word   (circle_word),
        .tangent_valid (tangent_valid),
        .tangent_stall (tangent_stall),
        .tangent_word  (tangent_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // 128-bit wide helpers keep every product exact
    function automatic logic [cot_pkg::COORD_W-1:0] place_point(
        logic signed [cot_pkg::COORD_W-1:0] centre, logic [cot_pkg::RADIUS_W-1:0] r,
        logic [63:0] q, bit neg);
        logic [127:0] prod;
        logic [127:0] off;
        logic signed [127:0] res;
        prod = 128'(r) * 128'(q) + (128'd1 << (cot_pkg::UNIT_BITS - 1));
        off  = prod >> cot_pkg::UNIT_BITS;
        res  = neg ? 128'(centre) - $signed(off) : 128'(centre) + $signed(off);
        if (res > 128'sh7fffffff)
            return 32'h7fffffff;
        if (res < -128'sh80000000)
            return 32'h80000000;
        return res[cot_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [63:0] unit_component(logic signed [127:0] num,
        logic [127:0] den, output bit neg);
        logic [127:0] a;
        logic [127:0] q;
        neg = num < 0;
        a   = neg ? -num : num;
        q   = ((a << (cot_pkg::UNIT_BITS + 1)) / den + 1) >> 1;
        if (q > (128'd1 << cot_pkg::UNIT_BITS))
            q = 128'd1 << cot_pkg::UNIT_BITS;
        return q[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        lo = 0;
        hi = 128'd1 << 32;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo[63:0];
    endfunction

    function automatic cot_pkg::tangent_word_t predict_tangents(cot_pkg::circle_word_t c);
        cot_pkg::tangent_word_t t;
        logic signed [127:0] dx, dy, k, h;
        logic [127:0] ax, ay, ak, m, d2, k2;
        logic [63:0] qx[2];
        logic [63:0] qy[2];
        bit sx[2];
        bit sy[2];
        logic [cot_pkg::COORD_W-1:0] pts[8];
        t  = '0;
        dx = 128'(c.second_center_x) - 128'(c.first_center_x);
        dy = 128'(c.second_center_y) - 128'(c.first_center_y);
        k  = $signed(128'(c.first_radius)) - $signed(128'(c.second_radius));
        if ((dx == 0 && dy == 0) || dx * dx + dy * dy < k * k)
            return t;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        ak = k < 0 ? -k : k;
        m  = ax | ay | ak;
        while (m >= (128'd1 << 30))
        begin
            ax = ax >> 1; ay = ay >> 1; ak = ak >> 1; m = m >> 1;
        end
        while (m < (128'd1 << 29))
        begin
            ax = ax << 1; ay = ay << 1; ak = ak << 1; m = m << 1;
        end
        d2 = ax * ax + ay * ay;
        if (d2 == 0)
            return t;
        k2 = ak * ak;
        h  = floor_sqrt(d2 > k2 ? d2 - k2 : 0);
        dx = dx < 0 ? -$signed(ax) : $signed(ax);
        dy = dy < 0 ? -$signed(ay) : $signed(ay);
        k  = k < 0 ? -$signed(ak) : $signed(ak);
        qx[0] = unit_component(dx * k - dy * h, d2, sx[0]);
        qy[0] = unit_component(dy * k + dx * h, d2, sy[0]);
        qx[1] = unit_component(dx * k + dy * h, d2, sx[1]);
        qy[1] = unit_component(dy * k - dx * h, d2, sy[1]);
        for (int ln = 0; ln < 2; ln++)
        begin
            pts[ln*4+0] = place_point(c.first_center_x, c.first_radius, qx[ln], sx[ln]);
            pts[ln*4+1] = place_point(c.first_center_y, c.first_radius, qy[ln], sy[ln]);
            pts[ln*4+2] = place_point(c.second_center_x, c.second_radius, qx[ln], sx[ln]);
            pts[ln*4+3] = place_point(c.second_center_y, c.second_radius, qy[ln], sy[ln]);
        end
        t.upper_first_point_x  = pts[0];
        t.upper_first_point_y  = pts[1];
        t.upper_second_point_x = pts[2];
        t.upper_second_point_y = pts[3];
        t.lower_first_point_x  = pts[4];
        t.lower_first_point_y  = pts[5];
        t.lower_second_point_x = pts[6];
        t.lower_second_point_y = pts[7];
        t.tangents_valid       = 1'b1;
        return t;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                           : 32'h80000000 + $urandom_range(0, 255);
            2: return $urandom_range(0, 4095) - 2048;
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        endcase
    endfunction

    function automatic int rand_radius();
        case ($urandom_range(0, 5))
            0: return int'($urandom >> 1);
            1: return 0;
            2: return int'(32'h7fffffff - $urandom_range(0, 255));
            default: return int'($urandom_range(0, 32'h00ffffff));
        endcase
    endfunction

    function automatic cot_pkg::circle_word_t make_pair(int x1, int y1, int r1,
        int x2, int y2, int r2);
        cot_pkg::circle_word_t c;
        c.first_center_x  = x1;
        c.first_center_y  = y1;
        c.first_radius    = cot_pkg::RADIUS_W'(r1);
        c.second_center_x = x2;
        c.second_center_y = y2;
        c.second_radius   = cot_pkg::RADIUS_W'(r2);
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_valid <= 1'b0;
            circle_word  <= '0;
        end
        else if (!circle_valid || !circle_stall)
        begin
            if (pending_circles.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                circle_valid <= 1'b1;
                circle_word  <= pending_circles.pop_front();
            end
            else
            begin
                circle_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && circle_valid && !circle_stall)
            expected_tangents.push_back(predict_tangents(circle_word));

    // receiver stall, with a long counted hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tangent_stall <= 1'b0;
            hold_count    <= 0;
        end
        else if (hold_off && hold_count < 300)
        begin
            tangent_stall <= 1'b1;
            hold_count    <= hold_count + 1;
        end
        else
        begin
            tangent_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cot_pkg::tangent_word_t e;
        if (rst_n && tangent_valid && !tangent_stall)
        begin
            if (expected_tangents.size() == 0)
            begin
                $error("tangent word with none expected");
                fail_count++;
            end
            else
            begin
                e = expected_tangents.pop_front();
                if (tangent_word.upper_first_point_x !== e.upper_first_point_x)
                begin
                    $error("upper_first_point_x exp %h got %h",
                           e.upper_first_point_x, tangent_word.upper_first_point_x);
                    fail_count++;
                end
                if (tangent_word.upper_first_point_y !== e.upper_first_point_y)
                begin
                    $error("upper_first_point_y exp %h got %h",
                           e.upper_first_point_y, tangent_word.upper_first_point_y);
                    fail_count++;
                end
                if (tangent_word.upper_second_point_x !== e.upper_second_point_x)
                begin
                    $error("upper_second_point_x exp %h got %h",
                           e.upper_second_point_x, tangent_word.upper_second_point_x);
                    fail_count++;
                end
                if (tangent_word.upper_second_point_y !== e.upper_second_point_y)
                begin
                    $error("upper_second_point_y exp %h got %h",
                           e.upper_second_point_y, tangent_word.upper_second_point_y);
                    fail_count++;
                end
                if (tangent_word.lower_first_point_x !== e.lower_first_point_x)
                begin
                    $error("lower_first_point_x exp %h got %h",
                           e.lower_first_point_x, tangent_word.lower_first_point_x);
                    fail_count++;
                end
                if (tangent_word.lower_first_point_y !== e.lower_first_point_y)
                begin
                    $error("lower_first_point_y exp %h got %h",
                           e.lower_first_point_y, tangent_word.lower_first_point_y);
                    fail_count++;
                end
                if (tangent_word.lower_second_point_x !== e.lower_second_point_x)
                begin
                    $error("lower_second_point_x exp %h got %h",
                           e.lower_second_point_x, tangent_word.lower_second_point_x);
                    fail_count++;
                end
                if (tangent_word.lower_second_point_y !== e.lower_second_point_y)
                begin
                    $error("lower_second_point_y exp %h got %h",
                           e.lower_second_point_y, tangent_word.lower_second_point_y);
                    fail_count++;
                end
                if (tangent_word.tangents_valid !== e.tangents_valid)
                begin
                    $error("tangents_valid exp %b got %b",
                           e.tangents_valid, tangent_word.tangents_valid);
                    fail_count++;
                end
            end
        end
    end

    task automatic run_phase(int n, int idle_pct, int stl_pct);
        logic [31:0] x1, y1, x2, y2;
        int r1, r2;
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        for (int i = 0; i < n; i++)
        begin
            x1 = rand_coord();
            y1 = rand_coord();
            r1 = rand_radius();
            r2 = rand_radius();
            case ($urandom_range(0, 9))
                0:
                begin
                    x2 = x1;
                    y2 = y1;
                end
                1:
                begin
                    x2 = x1 + $urandom_range(0, 3);
                    y2 = y1;
                end
                default:
                begin
                    x2 = rand_coord();
                    y2 = rand_coord();
                end
            endcase
            pending_circles.push_back(make_pair(x1, y1, r1, x2, y2, r2));
        end
        while (pending_circles.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, coincident, nested, internally tangent, zero radius
        pending_circles.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_circles.push_back(make_pair(100, 200, 5 << 16, 100, 200, 7 << 16));
        pending_circles.push_back(make_pair(0, 0, 10 << 16, 1 << 16, 0, 2 << 16));
        pending_circles.push_back(make_pair(0, 0, 10 << 16, 8 << 16, 0, 2 << 16));
        pending_circles.push_back(make_pair(0, 0, 2 << 16, 8 << 16, 0, 10 << 16));
        pending_circles.push_back(make_pair(0, 0, 0, 5 << 16, 5 << 16, 0));
        pending_circles.push_back(make_pair(0, 0, 3 << 16, 10 << 16, 0, 3 << 16));
        pending_circles.push_back(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff,
                                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_circles.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                            32'h80000000, 32'h80000000, 0));
        pending_circles.push_back(make_pair(32'h7fffff00, 0, 32'h7fffffff,
                                            32'h7fffffff, 0, 32'h7ffffffe));
        pending_circles.push_back(make_pair(32'h80000000, 32'h7fffffff, 0,
                                            32'h7fffffff, 32'h80000000, 32'h7fffffff));
        pending_circles.push_back(make_pair(0, 0, 1, 0, 1, 0));
        pending_circles.push_back(make_pair(-5, 7, 1000, 9, -3, 1));
        pending_circles.push_back(make_pair(32'hffffffff, 32'hffffffff, 32'h55555555,
                                            32'h55555555, 32'haaaaaaaa, 32'h2aaaaaaa));
        run_phase(0, 0, 0);

        run_phase(300, 0, 0);
        // long hold-off while the sender keeps offering
        hold_off = 1'b1;
        run_phase(250, 0, 0);
        hold_off = 1'b0;
        run_phase(270, 55, 0);
        run_phase(270, 0, 55);
        run_phase(270, 29, 29);

        stall_pct     = 0;
        while (expected_tangents.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cot_pkg.sv
src/cot_sqrt.sv
src/cot_div.sv
src/circle_outer_tangent_points_top.sv
bench/testbench.sv
